### rtl/cti_pkg.sv
// Shared types, constants and codes of the clamped table interpolator.
`default_nettype none
package cti_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int COUNT_W     = ADDR_W + 1;

	localparam int POS_W = 24;
	localparam int VAL_W = 20;
	localparam int UNC_W = 19;

	// Dipole constants: P = 71 * 2^16, P^2 = 5041 * 2^32, scale of x is 100
	localparam logic [30:0] DIP_P     = 31'd4653056;
	localparam logic [31:0] DIP_P2_HI = 32'd5041;
	localparam logic [31:0] DIP_XMUL  = 32'd100;

	localparam logic [UNC_W-1:0] UNC_MAX = '1;

	// Mode codes
	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic        [POS_W-1:0] pos;
		logic signed [VAL_W-1:0] val;
		logic        [UNC_W-1:0] unc;
	} entry_t;

	typedef enum logic [13:0] {
		S_IDLE  = 14'b00000000000001,
		S_FIRST = 14'b00000000000010,
		S_LAST  = 14'b00000000000100,
		S_SCAN  = 14'b00000000001000,
		S_LMUL  = 14'b00000000010000,
		S_LLOAD = 14'b00000000100000,
		S_DIV   = 14'b00000001000000,
		S_LFIX  = 14'b00000010000000,
		S_DA    = 14'b00000100000000,
		S_DB    = 14'b00001000000000,
		S_DC    = 14'b00010000000000,
		S_DD    = 14'b00100000000000,
		S_DM    = 14'b01000000000000,
		S_DLOAD = 14'b10000000000000
	} state_t;

endpackage
`default_nettype wire

### rtl/clamped_table_interpolator.sv
// Top level: point table, linear scan, shared multiplier and divider sequencer.
//
// Usage: drive mode and the load/query fields with start high; the item is
// taken at a clock edge where start is high and busy is low. Exactly one
// result beat follows per item, shown for one cycle with done high.
// Clear, load, unused mode 3 and a query on an empty table need no sequencer:
// done rises the cycle after acceptance and busy never rises.
// A query reads the first and the last entry through the single memory port.
// Inside the table it then scans one entry per cycle up to the bracket and
// runs two lerps; every query ends with two dipole divisions. All of these
// share one 32x32 multiplier and one 21-step restoring divider. done rises
// in the same cycle that busy falls.
// Reset clears the point count and the sequencer; table contents are not
// cleared and only entries below the count are ever read.
// The receiver cannot stall: each result is taken in the cycle it is shown,
// and the next item may be started in that same cycle.
`default_nettype none
module clamped_table_interpolator import cti_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [1:0]               mode,
	input  wire logic [POS_W-1:0]         abscissa,
	input  wire logic signed [VAL_W-1:0]  ratio_value,
	input  wire logic signed [VAL_W-1:0]  param_uncertainty,
	input  wire logic signed [VAL_W-1:0]  measured_uncertainty,
	output logic                          done,
	output logic signed [VAL_W-1:0]       scaled_value,
	output logic [UNC_W-1:0]              scaled_uncertainty,
	output logic [1:0]                    status
);

	state_t state_q;
	logic   dp_q;
	logic   lane_q;

	logic [COUNT_W-1:0] count_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [ADDR_W-1:0]  last_idx;
	logic [ADDR_W-1:0]  rd_addr;
	logic [POS_W-1:0]   x_q;

	entry_t mem_q [TABLE_DEPTH];
	entry_t rd_q;
	entry_t prev_q;
	entry_t cur_q;
	entry_t new_entry;
	logic   wr_en;

	logic signed [21:0] val_q;
	logic signed [21:0] unc_q;
	logic signed [21:0] y0_q;
	logic               neg_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod_q;
	logic [30:0] d_q;
	logic [61:0] d2_q;

	logic [61:0] div_rem_q;
	logic [61:0] div_den_q;
	logic [20:0] div_low_q;
	logic [20:0] div_quo_q;
	logic [4:0]  div_cnt_q;
	logic [62:0] div_trial;
	logic [63:0] div_diff;
	logic        div_ge;

	logic signed [21:0] ly0;
	logic signed [21:0] ly1;
	logic signed [21:0] ldy;
	logic [19:0]        lady;
	logic [POS_W-1:0]   ldx;
	logic [POS_W-1:0]   lden;
	logic signed [21:0] lfl;
	logic signed [21:0] ly;
	logic [19:0]        dmag;
	logic [64:0]        dnum;
	logic signed [20:0] mu_abs;
	logic [UNC_W-1:0]   load_unc;

	logic [1:0]               st_next;
	logic                     done_d;
	logic                     done_q;
	logic signed [VAL_W-1:0]  sv_q;
	logic [UNC_W-1:0]         su_q;
	logic [1:0]               st_q;

	assign busy               = (state_q != S_IDLE);
	assign done               = done_q;
	assign scaled_value       = sv_q;
	assign scaled_uncertainty = su_q;
	assign status             = st_q;

	assign last_idx = ADDR_W'(count_q - COUNT_W'(1));

	// Pick the stored uncertainty of a load
	always_comb begin
		mu_abs = measured_uncertainty[VAL_W-1] ? -21'(measured_uncertainty)
		                                       : 21'(measured_uncertainty);
		if (!param_uncertainty[VAL_W-1] && param_uncertainty != '0)
			load_unc = param_uncertainty[UNC_W-1:0];
		else if (mu_abs > 21'(UNC_MAX))
			load_unc = UNC_MAX;
		else
			load_unc = mu_abs[UNC_W-1:0];
	end

	assign new_entry = '{pos: abscissa, val: ratio_value, unc: load_unc};
	assign wr_en = (state_q == S_IDLE) && start && (mode == MODE_LOAD)
	               && (count_q < COUNT_W'(TABLE_DEPTH));

	// Status of an item taken in idle
	always_comb begin
		st_next = ST_OK;
		if (mode == MODE_LOAD && count_q >= COUNT_W'(TABLE_DEPTH))
			st_next = ST_FULL;
		else if (mode == MODE_QUERY && count_q == '0)
			st_next = ST_EMPTY;
	end

	// Raise the result beat for items that need no sequencer and after the last division
	assign done_d = ((state_q == S_IDLE) && start
	                 && !(mode == MODE_QUERY && count_q != '0))
	                || ((state_q == S_DIV) && (div_cnt_q == '0) && dp_q && lane_q);

	// Select the read address for the next cycle
	always_comb begin
		unique case (state_q)
			S_FIRST: rd_addr = last_idx;
			S_LAST:  rd_addr = ADDR_W'(1);
			S_SCAN:  rd_addr = idx_q + ADDR_W'(1);
			default: rd_addr = '0;
		endcase
	end

	// Point table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[count_q[ADDR_W-1:0]] <= new_entry;
		rd_q <= mem_q[rd_addr];
	end

	// Lerp operands of the current lane
	always_comb begin
		ly0 = lane_q ? 22'(prev_q.unc) : 22'(prev_q.val);
		ly1 = lane_q ? 22'(cur_q.unc)  : 22'(cur_q.val);
		ldy = ly1 - ly0;
		lady = ldy[21] ? 20'(-ldy) : ldy[19:0];
		ldx = x_q - prev_q.pos;
		lden = cur_q.pos - prev_q.pos;
		lfl = 22'(div_quo_q) + 22'(neg_q && (div_rem_q != '0));
		ly = neg_q ? (y0_q - lfl) : (y0_q + lfl);
		dmag = lane_q ? unc_q[19:0] : (val_q[21] ? 20'(-val_q) : val_q[19:0]);
		dnum = {1'b0, prod_q[31:0], 32'b0} + {4'b0, d2_q[61:1]};
	end

	// Shared multiplier operands
	always_comb begin
		unique case (state_q)
			S_LMUL:  begin mul_a = 32'(lady); mul_b = 32'(ldx); end
			S_DA:    begin mul_a = 32'(x_q); mul_b = DIP_XMUL; end
			S_DC:    begin mul_a = 32'(d_q); mul_b = 32'(d_q); end
			S_DM:    begin mul_a = 32'(dmag); mul_b = DIP_P2_HI; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// Divider step: shift in one dividend bit, subtract if it fits
	assign div_trial = {div_rem_q, div_low_q[20]};
	assign div_diff  = {1'b0, div_trial} - {2'b0, div_den_q};
	assign div_ge    = ~div_diff[63];

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE:  x_q <= abscissa;
			S_FIRST: begin
				prev_q <= rd_q;
				val_q  <= 22'(rd_q.val);
				unc_q  <= 22'(rd_q.unc);
			end
			S_LAST: begin
				val_q <= 22'(rd_q.val);
				unc_q <= 22'(rd_q.unc);
			end
			S_SCAN: begin
				if (idx_q == last_idx || rd_q.pos > x_q)
					cur_q <= rd_q;
				else
					prev_q <= rd_q;
			end
			S_LMUL: begin
				y0_q  <= ly0;
				neg_q <= ldy[21];
			end
			S_LLOAD: begin
				div_rem_q <= 62'(prod_q[43:21]);
				div_low_q <= prod_q[20:0];
				div_den_q <= 62'(lden);
			end
			S_DIV: begin
				div_rem_q <= div_ge ? div_diff[61:0] : div_trial[61:0];
				div_low_q <= {div_low_q[19:0], 1'b0};
				div_quo_q <= {div_quo_q[19:0], div_ge};
			end
			S_LFIX: begin
				if (lane_q)
					unc_q <= ly;
				else
					val_q <= ly;
			end
			S_DB: d_q <= DIP_P + prod_q[30:0];
			S_DD: d2_q <= prod_q[61:0];
			S_DLOAD: begin
				div_rem_q <= 62'(dnum[64:21]);
				div_low_q <= dnum[20:0];
				div_den_q <= d2_q;
			end
			default: ;
		endcase
	end

	// Sequencer, point count and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			dp_q      <= 1'b0;
			lane_q    <= 1'b0;
			div_cnt_q <= '0;
			done_q    <= 1'b0;
			sv_q      <= '0;
			su_q      <= '0;
			st_q      <= ST_OK;
		end else begin
			done_q <= done_d;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						sv_q <= '0;
						su_q <= '0;
						st_q <= st_next;
						lane_q <= 1'b0;
						priority if (mode == MODE_CLEAR) begin
							count_q <= '0;
						end else if (mode == MODE_LOAD) begin
							if (wr_en)
								count_q <= count_q + COUNT_W'(1);
						end else if (mode == MODE_QUERY) begin
							if (count_q != '0)
								state_q <= S_FIRST;
						end else begin
							// drop unused mode
						end
					end
				end
				S_FIRST: state_q <= (x_q <= rd_q.pos) ? S_DA : S_LAST;
				S_LAST: begin
					if (x_q >= rd_q.pos) begin
						state_q <= S_DA;
					end else begin
						idx_q   <= ADDR_W'(1);
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q == last_idx || rd_q.pos > x_q)
						state_q <= S_LMUL;
					else
						idx_q <= idx_q + ADDR_W'(1);
				end
				S_LMUL:  state_q <= S_LLOAD;
				S_LLOAD: begin
					dp_q      <= 1'b0;
					div_cnt_q <= 5'd20;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					if (div_cnt_q == '0) begin
						if (!dp_q)
							state_q <= S_LFIX;
						else begin
							// finish a dipole division directly
							if (lane_q) begin
								state_q <= S_IDLE;
							end else begin
								lane_q  <= 1'b1;
								state_q <= S_DM;
							end
						end
					end else begin
						div_cnt_q <= div_cnt_q - 5'd1;
					end
				end
				S_LFIX: begin
					if (lane_q) begin
						lane_q  <= 1'b0;
						state_q <= S_DA;
					end else begin
						lane_q  <= 1'b1;
						state_q <= S_LMUL;
					end
				end
				S_DA: state_q <= S_DB;
				S_DB: state_q <= S_DC;
				S_DC: state_q <= S_DD;
				S_DD: state_q <= S_DM;
				S_DM: state_q <= S_DLOAD;
				S_DLOAD: begin
					dp_q      <= 1'b1;
					div_cnt_q <= 5'd20;
					state_q   <= S_DIV;
				end
				default: state_q <= S_IDLE;
			endcase

			// Capture the final quotient bit into the result on the last step
			if (state_q == S_DIV && div_cnt_q == '0 && dp_q) begin
				if (lane_q) begin
					su_q <= {div_quo_q[UNC_W-2:0], div_ge};
				end else begin
					sv_q <= val_q[21] ? -VAL_W'({div_quo_q[19:0], div_ge})
					                  : VAL_W'({div_quo_q[19:0], div_ge});
				end
			end
		end
	end

endmodule
`default_nettype wire

### tb/sv/clamped_table_interpolator_tb.sv
// Self-checking testbench of the clamped table interpolator.
`timescale 1ns / 1ps
`default_nettype none
module clamped_table_interpolator_tb import cti_pkg::*; ();

	typedef struct {
		logic signed [VAL_W-1:0] val;
		logic [UNC_W-1:0]        unc;
		logic [1:0]              st;
	} lookup_t;

	// Table model and queue of pending lookup results
	class lookup_scoreboard;
		logic [POS_W-1:0]        pos_tab[TABLE_DEPTH];
		logic signed [VAL_W-1:0] val_tab[TABLE_DEPTH];
		logic [UNC_W-1:0]        unc_tab[TABLE_DEPTH];
		int unsigned             fill;
		lookup_t                 pending[$];
		int                      errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function longint floor_quot(longint n, longint d);
			longint q;
			q = n / d;
			if ((n % d) != 0 && n < 0)
				q--;
			return q;
		endfunction

		function longint seg_interp(longint y0, longint y1, longint x0,
			longint x1, longint x);
			return y0 + floor_quot((y1 - y0) * (x - x0), x1 - x0);
		endfunction

		// Multiply by (P/D)^2, round half away from zero
		function longint dipole(longint v, longint x);
			logic [127:0] d2;
			logic [127:0] n;
			logic [127:0] mag;
			logic [127:0] r;
			d2 = (4653056 + 100 * x) * (4653056 + 100 * x);
			n = 128'd4653056 * 128'd4653056;
			mag = (v < 0) ? -v : v;
			r = (mag * n + d2 / 2) / d2;
			return (v < 0) ? -longint'(r) : longint'(r);
		endfunction

		function void note_item(logic [1:0] md, logic [POS_W-1:0] x,
			logic signed [VAL_W-1:0] rv, logic signed [VAL_W-1:0] pu,
			logic signed [VAL_W-1:0] mu);
			lookup_t e;
			longint s, v, u;
			int unsigned i, last;
			e.val = '0;
			e.unc = '0;
			e.st = ST_OK;
			if (md == MODE_CLEAR) begin
				fill = 0;
			end else if (md == MODE_LOAD) begin
				if (fill >= TABLE_DEPTH) begin
					e.st = ST_FULL;
				end else begin
					s = (pu > 0) ? longint'(pu)
					             : ((mu < 0) ? -longint'(mu) : longint'(mu));
					if (s > 524287)
						s = 524287;
					pos_tab[fill] = x;
					val_tab[fill] = rv;
					unc_tab[fill] = s[UNC_W-1:0];
					fill++;
				end
			end else if (md == MODE_QUERY) begin
				if (fill == 0) begin
					e.st = ST_EMPTY;
				end else begin
					last = fill - 1;
					if (x <= pos_tab[0]) begin
						v = val_tab[0];
						u = unc_tab[0];
					end else if (x >= pos_tab[last]) begin
						v = val_tab[last];
						u = unc_tab[last];
					end else begin
						i = 1;
						while (i < last && pos_tab[i] <= x)
							i++;
						v = seg_interp(val_tab[i-1], val_tab[i],
							pos_tab[i-1], pos_tab[i], x);
						u = seg_interp(unc_tab[i-1], unc_tab[i],
							pos_tab[i-1], pos_tab[i], x);
					end
					v = dipole(v, x);
					u = dipole(u, x);
					e.val = v[VAL_W-1:0];
					e.unc = u[UNC_W-1:0];
				end
			end
			pending = {pending, e};
		endfunction

		function void check_result(logic signed [VAL_W-1:0] v, logic [UNC_W-1:0] u,
			logic [1:0] st);
			lookup_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: val %0d unc %0d st %0d", v, u, st);
				return;
			end
			e = pending.pop_front();
			if (v !== e.val || u !== e.unc || st !== e.st) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: exp val %0d unc %0d st %0d, got val %0d unc %0d st %0d",
						e.val, e.unc, e.st, v, u, st);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] mode;
	logic [POS_W-1:0] abscissa;
	logic signed [VAL_W-1:0] ratio_value;
	logic signed [VAL_W-1:0] param_uncertainty;
	logic signed [VAL_W-1:0] measured_uncertainty;
	logic done;
	logic signed [VAL_W-1:0] scaled_value;
	logic [UNC_W-1:0] scaled_uncertainty;
	logic [1:0] status;

	lookup_scoreboard sb;
	int unsigned cycles;
	bit calm;

	clamped_table_interpolator u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.abscissa(abscissa), .ratio_value(ratio_value),
		.param_uncertainty(param_uncertainty),
		.measured_uncertainty(measured_uncertainty), .done(done),
		.scaled_value(scaled_value), .scaled_uncertainty(scaled_uncertainty),
		.status(status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Check every result beat; bound the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			sb.check_result(scaled_value, scaled_uncertainty, status);
		if (cycles > 3000000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Send one beat: drive at falling edge, hold until accepted
	task automatic send_item(logic [1:0] md, logic [POS_W-1:0] x,
		logic signed [VAL_W-1:0] rv, logic signed [VAL_W-1:0] pu,
		logic signed [VAL_W-1:0] mu);
		bit taken;
		while (!calm && $urandom_range(99) < 23) begin
			start <= 1'b0;
			@(negedge clk);
		end
		mode <= md;
		abscissa <= x;
		ratio_value <= rv;
		param_uncertainty <= pu;
		measured_uncertainty <= mu;
		start <= 1'b1;
		taken = 0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			if (taken)
				sb.note_item(md, x, rv, pu, mu);
		end
		@(negedge clk);
	endtask

	task automatic load_pt(logic [POS_W-1:0] x);
		send_item(MODE_LOAD, x, VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
	endtask

	task automatic query_at(logic [POS_W-1:0] x);
		send_item(MODE_QUERY, x, VAL_W'($urandom), VAL_W'($urandom), VAL_W'($urandom));
	endtask

	initial begin
		int unsigned n, k, base;
		sb = new();
		cycles = 0;
		calm = 0;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_CLEAR;
		abscissa = '0;
		ratio_value = '0;
		param_uncertainty = '0;
		measured_uncertainty = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty query, extremes, uncertainty selection, clamps, mode 3
		query_at(24'd100);
		send_item(MODE_LOAD, 24'h000100, 20'sh7FFFF, 20'sh00010, 20'sh00000);
		send_item(MODE_LOAD, 24'h010000, -20'sh80000, 20'sh00000, -20'sh80000);
		send_item(MODE_LOAD, 24'h800000, 20'sh01000, -20'sh00005, 20'sh7FFFF);
		send_item(MODE_LOAD, 24'hFFFFFF, -20'sh00001, 20'sh7FFFF, 20'sh00003);
		query_at(24'h000000);
		query_at(24'h000100);
		query_at(24'h008000);
		query_at(24'h400000);
		query_at(24'hFFFFFE);
		query_at(24'hFFFFFF);
		send_item(MODE_NONE, 24'hABCDEF, 20'sh12345, 20'sh1, 20'sh1);
		send_item(MODE_CLEAR, 24'hFFFFFF, -20'sh1, -20'sh1, -20'sh1);
		// Unsorted table
		load_pt(24'h300000);
		load_pt(24'h100000);
		load_pt(24'h500000);
		query_at(24'h200000);
		query_at(24'h400000);
		query_at(24'h300000);
		// Single point table
		send_item(MODE_CLEAR, '0, '0, '0, '0);
		load_pt(24'h020000);
		query_at(24'h010000);
		query_at(24'h030000);

		// Fill to the limit once, then overflow loads, a query past the last point and a random query
		send_item(MODE_CLEAR, '0, '0, '0, '0);
		for (k = 0; k < TABLE_DEPTH + 3; k++)
			load_pt(POS_W'(k * 65000));
		query_at(24'hFFF000);
		query_at(POS_W'($urandom_range(24'hFD0000)));

		// Random: mostly sorted tables with queries, some noise and unsorted tables
		calm = 1;
		for (n = 0; n < 1500; ) begin
			if (n > 400)
				calm = 0;
			send_item(MODE_CLEAR, POS_W'($urandom), VAL_W'($urandom),
				VAL_W'($urandom), VAL_W'($urandom));
			n++;
			k = $urandom_range(1, 12);
			base = $urandom_range(24'hFF0000);
			for (int j = 0; j < k; j++) begin
				if ($urandom_range(9) == 0)
					load_pt(POS_W'($urandom));
				else begin
					base = base + $urandom_range(1, 24'h100000);
					if (base > 24'hFFFFFF)
						base = $urandom_range(24'hFFFFFF);
					load_pt(POS_W'(base));
				end
				n++;
			end
			k = $urandom_range(1, 8);
			for (int j = 0; j < k; j++) begin
				case ($urandom_range(9))
					0: send_item(MODE_NONE, POS_W'($urandom), VAL_W'($urandom),
						VAL_W'($urandom), VAL_W'($urandom));
					1: load_pt(POS_W'($urandom));
					default: query_at(POS_W'($urandom));
				endcase
				n++;
			end
		end

		// Drain and settle
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
rtl/cti_pkg.sv
rtl/clamped_table_interpolator.sv
tb/sv/clamped_table_interpolator_tb.sv
